/* rtl/qrdt_pkg.sv */
// qrdt_pkg: shared codes and types for the delay estimate table.
// Used by qrdt_front, qrdt_back and q_routing_delay_table.
`timescale 1ns / 1ps
package qrdt_pkg;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_LATCH  = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;

    localparam logic [1:0] REG_ETA   = 2'd0;
    localparam logic [1:0] REG_DELTA = 2'd1;

    localparam int EST_W    = 40;
    localparam int SAMPLE_W = 37;
    localparam int ETA_W    = 17;
    localparam int DELTA_W  = 20;

    localparam logic [ETA_W-1:0]   ETA_ONE     = 17'd65536;
    localparam logic [ETA_W-1:0]   ETA_RESET   = 17'd6554;
    localparam logic [DELTA_W-1:0] DELTA_RESET = 20'd6554;

    typedef struct packed {
        logic [1:0]          op;
        logic                in_range;
        logic [2:0]          iface;
        logic [SAMPLE_W-1:0] sample;
    } qrdt_item_t;

    typedef struct packed {
        logic       valid;
        qrdt_item_t item;
    } qrdt_queue_t;

endpackage

/* rtl/qrdt_front.sv */
// qrdt_front: accepts input beats, classifies them and queues them.
// Depends on qrdt_pkg.
`timescale 1ns / 1ps
module qrdt_front #(
    parameter int NUM_IFACES = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    input  logic [2:0]           iface,
    input  logic [35:0]          piggy_us,
    input  logic [23:0]          rtt_us,
    output qrdt_pkg::qrdt_queue_t q_head,
    input  logic                 q_pop
);
    import qrdt_pkg::*;

    qrdt_item_t  fifo_mem [2];
    qrdt_item_t  new_item;
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && (count_reg != 2'd0);

    always_comb
    begin
        new_item.op       = op;
        new_item.iface    = iface;
        new_item.in_range = (32'(iface) < NUM_IFACES);
        new_item.sample   = SAMPLE_W'(piggy_us) + SAMPLE_W'(rtt_us);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.item  = fifo_mem[rd_ptr_reg];

endmodule

/* rtl/qrdt_back.sv */
// qrdt_back: estimate memory, shared multiplier sequencer, minimum scan
// and output register. Depends on qrdt_pkg.
`timescale 1ns / 1ps
module qrdt_back #(
    parameter int NUM_IFACES = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [qrdt_pkg::ETA_W-1:0]     eta_q16,
    input  logic [qrdt_pkg::DELTA_W-1:0]   delta_q16,
    input  qrdt_pkg::qrdt_queue_t          q_head,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [39:0]                    cur_min_us,
    output logic                           cur_min_valid,
    output logic [2:0]                     snap_iface,
    output logic                           continue_exploit
);
    import qrdt_pkg::*;

    localparam int IW = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
    localparam int CW = $clog2(NUM_IFACES + 1);
    localparam int ACC_W = 61;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [EST_W-1:0]   est_mem [NUM_IFACES];
    logic [NUM_IFACES-1:0] vld_reg;
    logic [EST_W-1:0]   rd_data_reg;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [EST_W-1:0]   wr_data;

    logic [2:0]         state_reg;
    qrdt_item_t         cur_reg;
    logic [EST_W-1:0]   q_reg;
    logic [EST_W-1:0]   diff_reg;
    logic [2:0]         step_reg;
    logic [39:0]        prod_reg;
    logic               sh_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_sum;
    logic               cont_reg;
    logic [CW-1:0]      cnt_reg;
    logic               found_reg;
    logic [EST_W-1:0]   best_reg;
    logic [IW-1:0]      best_idx_reg;
    logic [EST_W-1:0]   snap_min_reg;
    logic [IW-1:0]      snap_idx_reg;

    logic               out_valid_reg;
    logic [39:0]        out_min_reg;
    logic               out_min_valid_reg;
    logic [2:0]         out_snap_reg;
    logic               out_cont_reg;

    logic [ETA_W-1:0]   eta_sat;
    logic [ETA_W-1:0]   w_old;
    logic [19:0]        mul_a;
    logic [19:0]        mul_b;
    logic               mul_sh;
    logic [2:0]         last_step;
    logic [IW-1:0]      cur_idx;
    logic [IW-1:0]      scan_idx;
    logic               start;

    assign eta_sat   = (eta_q16 > ETA_ONE) ? ETA_ONE : eta_q16;
    assign w_old     = ETA_ONE - eta_sat;
    assign cur_idx   = IW'(cur_reg.iface);
    assign scan_idx  = IW'(cnt_reg - CW'(1));
    assign last_step = (cur_reg.op == OP_UPDATE) ? 3'd4 : 3'd2;
    assign start     = (state_reg == S_IDLE) && q_head.valid && !out_valid_reg;
    assign q_pop     = start;
    assign acc_sum   = acc_reg + (ACC_W'(prod_reg) << (sh_reg ? 20 : 0));

    always_comb
    begin
        mul_a  = 20'd0;
        mul_b  = 20'd0;
        mul_sh = 1'b0;
        if (cur_reg.op == OP_UPDATE)
        begin
            case (step_reg)
                3'd0:
                begin
                    mul_a = 20'(w_old);
                    mul_b = q_reg[19:0];
                end
                3'd1:
                begin
                    mul_a  = 20'(w_old);
                    mul_b  = q_reg[39:20];
                    mul_sh = 1'b1;
                end
                3'd2:
                begin
                    mul_a = 20'(eta_sat);
                    mul_b = cur_reg.sample[19:0];
                end
                3'd3:
                begin
                    mul_a  = 20'(eta_sat);
                    mul_b  = 20'(cur_reg.sample[36:20]);
                    mul_sh = 1'b1;
                end
                default:
                begin
                    mul_a = 20'd0;
                end
            endcase
        end
        else
        begin
            mul_a  = delta_q16;
            mul_b  = (step_reg == 3'd0) ? snap_min_reg[19:0] : snap_min_reg[39:20];
            mul_sh = (step_reg != 3'd0);
        end
    end

    always_comb
    begin
        rd_addr = IW'(cnt_reg);
        if (state_reg == S_IDLE)
        begin
            rd_addr = IW'(q_head.item.iface);
        end
        wr_en   = 1'b0;
        wr_addr = cur_idx;
        wr_data = EST_W'(cur_reg.sample);
        if (state_reg == S_LOAD && cur_reg.op == OP_UPDATE && cur_reg.in_range
            && !vld_reg[cur_idx])
        begin
            wr_en = 1'b1;
        end
        if (state_reg == S_MUL && step_reg == last_step && cur_reg.op == OP_UPDATE)
        begin
            wr_en   = 1'b1;
            wr_data = acc_sum[55:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            est_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= est_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_reg <= q_head.item;
        end
        prod_reg <= mul_a * mul_b;
        sh_reg   <= mul_sh;
        if (state_reg == S_LOAD)
        begin
            q_reg    <= rd_data_reg;
            diff_reg <= (snap_min_reg >= rd_data_reg) ? snap_min_reg - rd_data_reg
                                                      : rd_data_reg - snap_min_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            vld_reg           <= '0;
            step_reg          <= 3'd0;
            acc_reg           <= '0;
            cont_reg          <= 1'b0;
            cnt_reg           <= '0;
            found_reg         <= 1'b0;
            best_reg          <= '0;
            best_idx_reg      <= '0;
            snap_min_reg      <= '0;
            snap_idx_reg      <= '0;
            out_valid_reg     <= 1'b0;
            out_min_reg       <= '0;
            out_min_valid_reg <= 1'b0;
            out_snap_reg      <= 3'd0;
            out_cont_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    step_reg  <= 3'd0;
                    acc_reg   <= '0;
                    cont_reg  <= 1'b0;
                    cnt_reg   <= '0;
                    found_reg <= 1'b0;
                    state_reg <= S_SCAN;
                    if (cur_reg.op == OP_UPDATE && cur_reg.in_range)
                    begin
                        if (!vld_reg[cur_idx])
                        begin
                            vld_reg[cur_idx] <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                    else if (cur_reg.op == OP_CHECK && cur_reg.in_range
                             && vld_reg[cur_idx])
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg != 3'd0)
                    begin
                        acc_reg <= acc_sum;
                    end
                    if (step_reg == last_step)
                    begin
                        if (cur_reg.op == OP_CHECK)
                        begin
                            cont_reg <= (ACC_W'({diff_reg, 16'd0}) <= acc_sum);
                        end
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg != '0 && vld_reg[scan_idx]
                        && (!found_reg || rd_data_reg < best_reg))
                    begin
                        found_reg    <= 1'b1;
                        best_reg     <= rd_data_reg;
                        best_idx_reg <= scan_idx;
                    end
                    if (32'(cnt_reg) == NUM_IFACES)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (cur_reg.op == OP_LATCH && found_reg)
                    begin
                        snap_min_reg <= best_reg;
                        snap_idx_reg <= best_idx_reg;
                        out_snap_reg <= 3'(best_idx_reg);
                    end
                    else
                    begin
                        out_snap_reg <= 3'(snap_idx_reg);
                    end
                    out_valid_reg     <= 1'b1;
                    out_min_reg       <= found_reg ? best_reg : '0;
                    out_min_valid_reg <= found_reg;
                    out_cont_reg      <= cont_reg;
                    state_reg         <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign cur_min_us       = out_min_reg;
    assign cur_min_valid    = out_min_valid_reg;
    assign snap_iface       = out_snap_reg;
    assign continue_exploit = out_cont_reg;

    a_fin_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> !out_valid_reg)
        else $error("result overwrites a pending beat");
    a_min_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_min_valid_reg) |-> (out_min_reg == '0))
        else $error("minimum nonzero with no valid entry");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == S_LOAD))
        else $error("pop without entering load");
    a_cont_check: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_cont_reg) |-> (cur_reg.op == OP_CHECK))
        else $error("continue set for a non-check op");

endmodule

/* rtl/q_routing_delay_table.sv */
// q_routing_delay_table: top level, configuration registers and the
// front queue and back sequencer. Depends on qrdt_pkg, qrdt_front, qrdt_back.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | op, iface, piggy_us, rtt_us
//  out     | output    | out_valid/out_stall| cur_min_us, cur_min_valid, snap_iface,
//          |           |                    | continue_exploit
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// With the back part idle, an accepted item passes through the load, scan and finish
// states, with the multiply steps between load and scan for an update of a set entry
// and for a check of a set entry; the minimum scan reads the single read port of the
// estimate memory, one entry a cycle.
// A new item leaves the queue only once the back part is idle and the result register
// is empty, so the back part takes no new item before it is through with the last one.
// Reset clears all valid bits at once; no clearing pass.
// A stalled output holds its beat; the two-entry queue keeps accepting meanwhile until it is full.
`timescale 1ns / 1ps
module q_routing_delay_table #(
    parameter int NUM_IFACES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [2:0]  iface,
    input  logic [35:0] piggy_us,
    input  logic [23:0] rtt_us,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [39:0] cur_min_us,
    output logic        cur_min_valid,
    output logic [2:0]  snap_iface,
    output logic        continue_exploit,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import qrdt_pkg::*;

    logic [ETA_W-1:0]   eta_reg;
    logic [DELTA_W-1:0] delta_reg;
    qrdt_queue_t        q_head;
    logic               q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_reg   <= ETA_RESET;
            delta_reg <= DELTA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_ETA)
            begin
                eta_reg <= cfg_data[ETA_W-1:0];
            end
            else if (cfg_index == REG_DELTA)
            begin
                delta_reg <= cfg_data;
            end
        end
    end

    qrdt_front #(
        .NUM_IFACES(NUM_IFACES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .iface    (iface),
        .piggy_us (piggy_us),
        .rtt_us   (rtt_us),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    qrdt_back #(
        .NUM_IFACES(NUM_IFACES)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .eta_q16          (eta_reg),
        .delta_q16        (delta_reg),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .cur_min_us       (cur_min_us),
        .cur_min_valid    (cur_min_valid),
        .snap_iface       (snap_iface),
        .continue_exploit (continue_exploit)
    );

endmodule
